[hw/rtl/gsrr_pkg.sv]
package gsrr_pkg;

	// fixed field widths
	localparam int VAL_W   = 32;
	localparam int COORD_W = 7;
	localparam int DIM_W   = 6;

	typedef enum logic [1:0] {
		ACT_WRITE   = 2'd0,
		ACT_READ    = 2'd1,
		ACT_SUM     = 2'd2,
		ACT_PRODUCT = 2'd3
	} action_t;

	// configuration register indexes
	localparam logic CFG_GRID_WIDTH  = 1'b0;
	localparam logic CFG_GRID_HEIGHT = 1'b1;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_RWAIT = 6'b000100,
		ST_AREA  = 6'b001000,
		ST_DRAIN = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

endpackage

[hw/rtl/grid_store_region_reduce_unit.sv]
// channel  | handshake           | payload
// ---------+---------------------+-------------------------------------------------
// input    | in_valid/in_ready   | action, col_a, row_a, col_b, row_b, write_value
// result   | out_valid/out_ready | result_value, status
// config   | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item at a time. A write, a point off the grid or an empty rectangle goes from
// idle straight to the done state, which loads the result register; a read passes a
// read-wait state first, and an area action first walks the clamped rectangle (one cell
// per cycle through the single read port of the cell memory) and then a drain state.
// After reset a clearing pass writes zero to all MAX_DIM*MAX_DIM cells, one a cycle;
// in_ready stays low until it ends. Config beats are taken at any time. A result
// waiting on out_ready holds the unit in its last state only once the next item has
// finished; the next input beat is still taken.
module grid_store_region_reduce_unit #(
	parameter int MAX_DIM   = 32,
	parameter int CELL_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  gsrr_pkg::action_t                    action,
	input  logic signed [gsrr_pkg::COORD_W-1:0]  col_a,
	input  logic signed [gsrr_pkg::COORD_W-1:0]  row_a,
	input  logic signed [gsrr_pkg::COORD_W-1:0]  col_b,
	input  logic signed [gsrr_pkg::COORD_W-1:0]  row_b,
	input  logic signed [gsrr_pkg::VAL_W-1:0]    write_value,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [gsrr_pkg::VAL_W-1:0]    result_value,
	output logic                                 status,
	// configuration channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_index,
	input  logic        [gsrr_pkg::DIM_W-1:0]    cfg_data
);
	import gsrr_pkg::*;

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int COL_W  = $clog2(MAX_DIM);
	localparam int ADDR_W = $clog2(DEPTH);

	// register write: zero reads as one, anything above MAX_DIM is capped
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (int'(v) > MAX_DIM)
			r = DIM_W'(MAX_DIM);
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] addr_of(input logic [COL_W-1:0] r,
		input logic [COL_W-1:0] c);
		return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
	endfunction

	localparam logic [DIM_W-1:0] DIM_RST = clamp_dim(DIM_W'(MAX_DIM));

	// cell memory, one write and one registered read port
	logic [CELL_BITS-1:0] mem [DEPTH];
	logic                 mem_we;
	logic [ADDR_W-1:0]    mem_waddr;
	logic [CELL_BITS-1:0] mem_wdata;
	logic [ADDR_W-1:0]    mem_raddr;
	logic [CELL_BITS-1:0] rdata_s1;
	logic                 rd_vld_s1;

	state_t              st_q;
	logic [ADDR_W-1:0]   clr_q;
	logic [DIM_W-1:0]    w_q;
	logic [DIM_W-1:0]    h_q;
	action_t             act_q;
	logic [COL_W-1:0]    c0_q, c1_q, r1_q;
	logic [COL_W-1:0]    c_q, r_q;
	logic [VAL_W-1:0]    res_q;
	logic                stat_q;
	logic                out_valid_q;
	logic [VAL_W-1:0]    out_res_q;
	logic                out_stat_q;

	logic                accept;
	logic                pt_in;
	logic [ADDR_W-1:0]   pt_addr;
	logic signed [8:0]   ca9, ra9, cb9, rb9, wm1, hm1;
	logic signed [8:0]   c0s, r0s, c1s, r1s;
	logic                area_empty;
	logic                walk_last;
	logic [VAL_W-1:0]    cell32;
	logic [VAL_W-1:0]    acc_sum, acc_prod;
	logic                done_go;

	assign in_ready  = (st_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// point check; negative coordinates are outside
	assign pt_in = !col_a[COORD_W-1] && !row_a[COORD_W-1]
		&& (col_a[DIM_W-1:0] < w_q) && (row_a[DIM_W-1:0] < h_q);
	assign pt_addr = addr_of(row_a[COL_W-1:0], col_a[COL_W-1:0]);

	// rectangle clamp, done in 9-bit signed so nothing wraps
	assign ca9 = 9'(col_a);
	assign ra9 = 9'(row_a);
	assign cb9 = 9'(col_b);
	assign rb9 = 9'(row_b);
	assign wm1 = $signed({3'b000, w_q}) - 9'sd1;
	assign hm1 = $signed({3'b000, h_q}) - 9'sd1;
	assign c0s = (ca9 < 9'sd0) ? 9'sd0 : ca9;
	assign r0s = (ra9 < 9'sd0) ? 9'sd0 : ra9;
	assign c1s = (cb9 > wm1) ? wm1 : cb9;
	assign r1s = (rb9 > hm1) ? hm1 : rb9;
	assign area_empty = (c0s > c1s) || (r0s > r1s);

	assign walk_last = (c_q == c1_q) && (r_q == r1_q);

	// cells are sign-extended or cut to 32 bits
	assign cell32   = VAL_W'($signed(rdata_s1));
	assign acc_sum  = res_q + cell32;
	assign acc_prod = res_q * cell32;

	assign done_go = (st_q == ST_DONE) && (!out_valid_q || out_ready);

	// memory ports
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pt_addr;
		mem_wdata = CELL_BITS'($signed(write_value));
		if (st_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (accept && action == ACT_WRITE && pt_in) begin
			mem_we = 1'b1;
		end
	end

	assign mem_raddr = (st_q == ST_AREA) ? addr_of(r_q, c_q) : pt_addr;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rdata_s1 <= mem[mem_raddr];
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= DIM_RST;
			h_q <= DIM_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_GRID_WIDTH:  w_q <= clamp_dim(cfg_data);
				CFG_GRID_HEIGHT: h_q <= clamp_dim(cfg_data);
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_CLEAR;
			clr_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (st_q == ST_AREA);
			unique case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(DEPTH - 1))
						st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						priority if (action == ACT_READ && pt_in)
							st_q <= ST_RWAIT;
						else if ((action == ACT_SUM || action == ACT_PRODUCT) && !area_empty)
							st_q <= ST_AREA;
						else
							st_q <= ST_DONE;
					end
				end
				ST_RWAIT: st_q <= ST_DONE;
				ST_AREA: begin
					if (walk_last)
						st_q <= ST_DRAIN;
				end
				ST_DRAIN: st_q <= ST_DONE;
				ST_DONE: begin
					if (done_go)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// item datapath; res_q doubles as the accumulator
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= action;
			c0_q   <= c0s[COL_W-1:0];
			c1_q   <= c1s[COL_W-1:0];
			r1_q   <= r1s[COL_W-1:0];
			c_q    <= c0s[COL_W-1:0];
			r_q    <= r0s[COL_W-1:0];
			stat_q <= (action == ACT_WRITE || action == ACT_READ) && !pt_in;
			res_q  <= (action == ACT_PRODUCT) ? VAL_W'(1) : '0;
		end
		if (st_q == ST_AREA) begin
			if (c_q == c1_q) begin
				c_q <= c0_q;
				r_q <= r_q + COL_W'(1);
			end else begin
				c_q <= c_q + COL_W'(1);
			end
		end
		if (st_q == ST_RWAIT)
			res_q <= cell32;
		else if (rd_vld_s1)
			res_q <= (act_q == ACT_SUM) ? acc_sum : acc_prod;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_go) begin
			out_res_q  <= res_q;
			out_stat_q <= stat_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = $signed(out_res_q);
	assign status       = out_stat_q;

	// checks
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("second item taken while one is in flight");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_CLEAR |-> !out_valid_q && !in_ready)
		else $error("activity during clearing pass");

	a_walk_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_AREA |-> c_q >= c0_q && c_q <= c1_q && r_q <= r1_q)
		else $error("area walk left its rectangle");

	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> st_q == ST_CLEAR || (accept && action == ACT_WRITE))
		else $error("stray cell write");

	a_drain_acc: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DRAIN |-> rd_vld_s1 && $past(st_q) == ST_AREA)
		else $error("last cell of area walk not accumulated");

endmodule
